@@ rtl/core/lpfc_pkg.sv @@
package lpfc_pkg;

  // Default width of the payload byte counter
  localparam int PAYLOAD_COUNT_BITS_DEFAULT = 32;

  // Register widths and reset value
  localparam int CAPACITY_BITS = 17;
  localparam logic [CAPACITY_BITS-1:0] HEADER_CAPACITY_RESET = 17'd4096;

  // Key text length, including both quotes
  localparam logic [3:0] KEY_LEN = 4'd14;

  // Characters the scanner looks for
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Frame region; the encoding is the region code on the output
  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Header scanner state
  typedef enum logic [2:0] {
    SC_KEY     = 3'd0,
    SC_COLON   = 3'd1,
    SC_SPACE   = 3'd2,
    SC_SIGN    = 3'd3,
    SC_DIGITS  = 3'd4,
    SC_DONE    = 3'd5,
    SC_NOVALUE = 3'd6,
    SC_NOKEY   = 3'd7
  } scan_t;

  // Frame status reported on the last byte
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_NO_KEY    = 3'd5,
    ST_NO_VALUE  = 3'd6,
    ST_MISMATCH  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  region;
    logic        frame_end;
    logic [2:0]  status;
    logic [31:0] payload_length;
  } out_item_t;

  // Character of the quoted key at a match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = CH_QUOTE;
      4'd1:    ch = 8'h70; // p
      4'd2:    ch = 8'h61; // a
      4'd3:    ch = 8'h79; // y
      4'd4:    ch = 8'h6C; // l
      4'd5:    ch = 8'h6F; // o
      4'd6:    ch = 8'h61; // a
      4'd7:    ch = 8'h64; // d
      4'd8:    ch = 8'h5F; // _
      4'd9:    ch = 8'h73; // s
      4'd10:   ch = 8'h69; // i
      4'd11:   ch = 8'h7A; // z
      4'd12:   ch = 8'h65; // e
      4'd13:   ch = CH_QUOTE;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

endpackage

@@ rtl/core/length_prefixed_frame_checker_unit.sv @@
// The result is registered: an accepted word sits in the input register, then the result register.
// One word per cycle when not stalled; all per-word work is a single combinational pass.
// The input stage accepts a new word while a finished result still waits downstream.
// Reset (rst, synchronous, active high) empties both stages, returns the frame to the
// length prefix with all counters and scanner state cleared, and sets header_capacity to 4096.
module length_prefixed_frame_checker_unit #(
  parameter int PAYLOAD_COUNT_BITS = lpfc_pkg::PAYLOAD_COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpfc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpfc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpfc_pkg::CAPACITY_BITS-1:0]  cfg_data
);

  // Configuration
  logic [lpfc_pkg::CAPACITY_BITS-1:0] header_capacity;

  // Input stage
  logic               stage_valid;
  lpfc_pkg::in_item_t stage_item;
  logic               advance;

  // Frame state
  lpfc_pkg::phase_t            phase, phase_next;
  logic [1:0]                  prefix_count, prefix_count_next;
  logic [31:0]                 header_length, header_length_next;
  logic [31:0]                 header_remaining, header_remaining_next;
  lpfc_pkg::scan_t             scan_phase, scan_phase_next;
  logic [3:0]                  key_match_position, key_match_position_next;
  logic [63:0]                 parsed_value, parsed_value_next;
  logic                        value_overflow, value_overflow_next;
  logic                        value_negative, value_negative_next;
  logic [PAYLOAD_COUNT_BITS-1:0] payload_count, payload_count_next;
  logic                        payload_count_saturated, payload_count_saturated_next;

  // Scanner helpers
  logic [7:0]  ch;
  logic        is_digit;
  logic [67:0] value_times_ten;
  logic [63:0] count_wide;

  // Result
  lpfc_pkg::status_t   status_now;
  lpfc_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  // Write the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_capacity <= lpfc_pkg::HEADER_CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_capacity <= cfg_data;
    end
  end

  // Hold the accepted word until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  assign ch       = stage_item.data_byte;
  assign is_digit = (ch >= lpfc_pkg::CH_ZERO) && (ch <= lpfc_pkg::CH_NINE);

  // Next value times ten plus digit; top bits flag overflow
  assign value_times_ten = ({4'b0, parsed_value} << 3) + ({4'b0, parsed_value} << 1)
                         + 68'(ch - lpfc_pkg::CH_ZERO);

  // Advance the frame and scanner state for one word
  always_comb begin
    phase_next                   = phase;
    prefix_count_next            = prefix_count;
    header_length_next           = header_length;
    header_remaining_next        = header_remaining;
    scan_phase_next              = scan_phase;
    key_match_position_next      = key_match_position;
    parsed_value_next            = parsed_value;
    value_overflow_next          = value_overflow;
    value_negative_next          = value_negative;
    payload_count_next           = payload_count;
    payload_count_saturated_next = payload_count_saturated;

    unique case (phase)
      lpfc_pkg::PH_PREFIX: begin
        header_length_next = {header_length[23:0], ch};
        prefix_count_next  = prefix_count + 2'd1;
        if (prefix_count == 2'd3) begin
          header_remaining_next = header_length_next;
          phase_next = (header_length_next == 32'd0) ? lpfc_pkg::PH_PAYLOAD
                                                     : lpfc_pkg::PH_HEADER;
        end
      end
      lpfc_pkg::PH_HEADER: begin
        // Scan the header text
        if (ch == lpfc_pkg::CH_NUL) begin
          unique case (scan_phase)
            lpfc_pkg::SC_KEY:    scan_phase_next = lpfc_pkg::SC_NOKEY;
            lpfc_pkg::SC_DIGITS: scan_phase_next = lpfc_pkg::SC_DONE;
            lpfc_pkg::SC_COLON,
            lpfc_pkg::SC_SPACE,
            lpfc_pkg::SC_SIGN:   scan_phase_next = lpfc_pkg::SC_NOVALUE;
            default:             scan_phase_next = scan_phase;
          endcase
        end else begin
          unique case (scan_phase)
            lpfc_pkg::SC_KEY: begin
              if ((key_match_position < lpfc_pkg::KEY_LEN) &&
                  (ch == lpfc_pkg::key_char(key_match_position))) begin
                key_match_position_next = key_match_position + 4'd1;
              end else begin
                key_match_position_next = (ch == lpfc_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
              end
              if (key_match_position_next >= lpfc_pkg::KEY_LEN) begin
                scan_phase_next = lpfc_pkg::SC_COLON;
              end
            end
            lpfc_pkg::SC_COLON: begin
              if (ch == lpfc_pkg::CH_COLON) begin
                scan_phase_next = lpfc_pkg::SC_SPACE;
              end
            end
            lpfc_pkg::SC_SPACE,
            lpfc_pkg::SC_SIGN,
            lpfc_pkg::SC_DIGITS: begin
              if (is_digit) begin
                if (|value_times_ten[67:64]) begin
                  value_overflow_next = 1'b1;
                  parsed_value_next   = '1;
                end else begin
                  parsed_value_next = value_times_ten[63:0];
                end
                scan_phase_next = lpfc_pkg::SC_DIGITS;
              end else if (scan_phase == lpfc_pkg::SC_DIGITS) begin
                scan_phase_next = lpfc_pkg::SC_DONE;
              end else if (scan_phase == lpfc_pkg::SC_SPACE && lpfc_pkg::is_space(ch)) begin
                scan_phase_next = scan_phase;
              end else if (scan_phase == lpfc_pkg::SC_SPACE &&
                           (ch == lpfc_pkg::CH_PLUS || ch == lpfc_pkg::CH_MINUS)) begin
                value_negative_next = (ch == lpfc_pkg::CH_MINUS);
                scan_phase_next     = lpfc_pkg::SC_SIGN;
              end else begin
                scan_phase_next = lpfc_pkg::SC_NOVALUE;
              end
            end
            default: scan_phase_next = scan_phase;
          endcase
        end
        header_remaining_next = header_remaining - 32'd1;
        if (header_remaining_next == 32'd0) begin
          phase_next = lpfc_pkg::PH_PAYLOAD;
        end
      end
      default: begin
        // Count payload, saturating
        if (&payload_count) begin
          payload_count_saturated_next = 1'b1;
        end else begin
          payload_count_next = payload_count + PAYLOAD_COUNT_BITS'(1);
        end
      end
    endcase
  end

  assign count_wide = 64'(payload_count_next);

  // Judge the frame from the updated state and build the result
  always_comb begin
    priority if (phase_next == lpfc_pkg::PH_PREFIX) begin
      status_now = lpfc_pkg::ST_SHORT;
    end else if (header_length_next == 32'd0) begin
      status_now = lpfc_pkg::ST_ZERO_LEN;
    end else if (header_remaining_next != 32'd0) begin
      status_now = lpfc_pkg::ST_TRUNCATED;
    end else if (header_length_next >= 32'(header_capacity)) begin
      status_now = lpfc_pkg::ST_TOO_LARGE;
    end else if (scan_phase_next == lpfc_pkg::SC_KEY ||
                 scan_phase_next == lpfc_pkg::SC_NOKEY) begin
      status_now = lpfc_pkg::ST_NO_KEY;
    end else if (scan_phase_next != lpfc_pkg::SC_DIGITS &&
                 scan_phase_next != lpfc_pkg::SC_DONE) begin
      status_now = lpfc_pkg::ST_NO_VALUE;
    end else if (value_overflow_next || payload_count_saturated_next) begin
      status_now = lpfc_pkg::ST_MISMATCH;
    end else if (value_negative_next && parsed_value_next != 64'd0) begin
      status_now = lpfc_pkg::ST_MISMATCH;
    end else if (parsed_value_next != count_wide) begin
      status_now = lpfc_pkg::ST_MISMATCH;
    end else begin
      status_now = lpfc_pkg::ST_OK;
    end

    result.out_byte       = ch;
    result.region         = phase;
    result.frame_end      = stage_item.last_byte;
    result.status         = '0;
    result.payload_length = '0;
    if (stage_item.last_byte) begin
      result.status         = status_now;
      result.payload_length = (|count_wide[63:32]) ? 32'hFFFF_FFFF : count_wide[31:0];
    end
  end

  // Commit frame state; drop it back to reset values at frame end
  always_ff @(posedge clk) begin
    if (rst || (advance && stage_item.last_byte)) begin
      phase                   <= lpfc_pkg::PH_PREFIX;
      prefix_count            <= '0;
      header_length           <= '0;
      header_remaining        <= '0;
      scan_phase              <= lpfc_pkg::SC_KEY;
      key_match_position      <= '0;
      parsed_value            <= '0;
      value_overflow          <= 1'b0;
      value_negative          <= 1'b0;
      payload_count           <= '0;
      payload_count_saturated <= 1'b0;
    end else if (advance) begin
      phase                   <= phase_next;
      prefix_count            <= prefix_count_next;
      header_length           <= header_length_next;
      header_remaining        <= header_remaining_next;
      scan_phase              <= scan_phase_next;
      key_match_position      <= key_match_position_next;
      parsed_value            <= parsed_value_next;
      value_overflow          <= value_overflow_next;
      value_negative          <= value_negative_next;
      payload_count           <= payload_count_next;
      payload_count_saturated <= payload_count_saturated_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  // Status and length are zero except on the frame end word
  a_idle_fields : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.frame_end) |-> (out_data.status == 3'd0 &&
                                            out_data.payload_length == 32'd0))
    else $error("status or length set on a non-final word");

  // Header phase always has bytes left to take
  a_header_left : assert property (@(posedge clk) disable iff (rst)
    (phase == lpfc_pkg::PH_HEADER) |-> (header_remaining != 32'd0))
    else $error("header phase with nothing remaining");

  // A frame end returns the frame to the length prefix
  a_frame_clear : assert property (@(posedge clk) disable iff (rst)
    (advance && stage_item.last_byte) |=> (phase == lpfc_pkg::PH_PREFIX &&
                                           prefix_count == 2'd0 &&
                                           payload_count == '0))
    else $error("frame state not cleared after frame end");

  // A waiting result is not overwritten
  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("result register overwritten while stalled");

  // Key match position stays within the key while searching
  a_key_range : assert property (@(posedge clk) disable iff (rst)
    (scan_phase == lpfc_pkg::SC_KEY) |-> (key_match_position < lpfc_pkg::KEY_LEN))
    else $error("key match position out of range");
`endif

endmodule
